// ===== design/ilb_pkg.sv =====
package ilb_pkg;

  localparam int CMD_W   = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int FOUND_W = 8;
  localparam int FILL_W  = 9;

  localparam logic [CMD_W-1:0] CMD_CLEAR        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SWAP_REMOVE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SHIFT_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIND_FIRST   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FIND_LAST    = 3'd5;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_CLOSE,
    CELL_WRITE
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e         mode;
    logic [VALUE_W-1:0] data;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_PATCH,
    ST_FINISH
  } ctrl_state_e;

endpackage

// ===== design/ilb_cell.sv =====
module ilb_cell
  import ilb_pkg::*;
#(
  parameter int IDX    = 0,
  parameter int ADDR_W = 9
) (
  input  logic               clk_i,
  input  cell_ctl_t          ctl_i,
  input  logic [ADDR_W-1:0]  addr_i,
  input  logic [VALUE_W-1:0] next_i,
  output logic [VALUE_W-1:0] data_o
);

  localparam logic [ADDR_W-1:0] MyIdx = ADDR_W'(IDX);

  logic [VALUE_W-1:0] data_q;
  logic [VALUE_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    case (ctl_i.mode)
      CELL_ROTATE: data_d = next_i;
      CELL_CLOSE: begin
        if (MyIdx >= addr_i) data_d = next_i;
      end
      CELL_WRITE: begin
        if (MyIdx == addr_i) data_d = ctl_i.data;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== design/ilb_ctrl.sv =====
module ilb_ctrl
  import ilb_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int CNT_W    = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [VALUE_W-1:0]  value_i,
  input  logic [POS_W-1:0]    position_i,
  input  logic [VALUE_W-1:0]  head_i,
  output cell_ctl_t           ctl_o,
  output logic [CNT_W-1:0]    addr_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                ok_o,
  output logic [FOUND_W-1:0]  found_at_o,
  output logic [FILL_W-1:0]   fill_o
);

  localparam int PW = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] Cap     = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] LastIdx = CNT_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] One     = CNT_W'(1);

  ctrl_state_e        state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   step_q, step_d;
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic               ok_q, ok_d;
  logic [CNT_W-1:0]   at_q, at_d;
  logic [VALUE_W-1:0] last_q, last_d;
  logic               out_valid_q, out_valid_d;
  logic               out_ok_q, out_ok_d;
  logic [FOUND_W-1:0] out_at_q, out_at_d;
  logic [FILL_W-1:0]  out_fill_q, out_fill_d;

  logic               pos_ok;
  logic               hit;

  assign pos_ok = PW'(position_i) < PW'(count_q);
  assign hit    = (step_q < count_q) && (head_i == val_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    cmd_d       = cmd_q;
    val_d       = val_q;
    pos_d       = pos_q;
    ok_d        = ok_q;
    at_d        = at_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_ok_d    = out_ok_q;
    out_at_d    = out_at_q;
    out_fill_d  = out_fill_q;
    ctl_o.mode  = CELL_HOLD;
    ctl_o.data  = value_i;
    addr_o      = count_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = command_i;
          val_d   = value_i;
          pos_d   = CNT_W'(position_i);
          ok_d    = 1'b0;
          at_d    = '0;
          step_d  = '0;
          state_d = ST_FINISH;
          case (command_i)
            CMD_CLEAR: begin
              count_d = '0;
              ok_d    = 1'b1;
            end
            CMD_APPEND: begin
              if (count_q != Cap) begin
                ctl_o.mode = CELL_WRITE;
                addr_o     = count_q;
                count_d    = count_q + One;
                ok_d       = 1'b1;
              end
            end
            CMD_SWAP_REMOVE: begin
              if (pos_ok) begin
                ok_d    = 1'b1;
                state_d = ST_WALK;
              end
            end
            CMD_SHIFT_REMOVE: begin
              if (pos_ok) begin
                ctl_o.mode = CELL_CLOSE;
                addr_o     = CNT_W'(position_i);
                count_d    = count_q - One;
                ok_d       = 1'b1;
              end
            end
            CMD_FIND_FIRST: state_d = ST_WALK;
            CMD_FIND_LAST:  state_d = ST_WALK;
            default:        state_d = ST_FINISH;
          endcase
        end
      end
      ST_WALK: begin
        ctl_o.mode = CELL_ROTATE;
        step_d     = step_q + One;
        case (cmd_q)
          CMD_SWAP_REMOVE: begin
            if (step_q == count_q - One) last_d = head_i;
          end
          CMD_FIND_FIRST: begin
            if (hit && !ok_q) begin
              ok_d = 1'b1;
              at_d = step_q;
            end
          end
          CMD_FIND_LAST: begin
            if (hit) begin
              ok_d = 1'b1;
              at_d = step_q;
            end
          end
          default: ;
        endcase
        if (step_q == LastIdx) begin
          state_d = (cmd_q == CMD_SWAP_REMOVE) ? ST_PATCH : ST_FINISH;
        end
      end
      ST_PATCH: begin
        ctl_o.mode = CELL_WRITE;
        ctl_o.data = last_q;
        addr_o     = pos_q;
        count_d    = count_q - One;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_ok_d    = ok_q;
          out_at_d    = FOUND_W'(at_q);
          out_fill_d  = FILL_W'(count_q);
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q     <= step_d;
    cmd_q      <= cmd_d;
    val_q      <= val_d;
    pos_q      <= pos_d;
    ok_q       <= ok_d;
    at_q       <= at_d;
    last_q     <= last_d;
    out_ok_q   <= out_ok_d;
    out_at_q   <= out_at_d;
    out_fill_q <= out_fill_d;
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign ok_o        = out_ok_q;
  assign found_at_o  = out_at_q;
  assign fill_o      = out_fill_q;

endmodule

// ===== design/integer_list_buffer_core.sv =====
// Fixed-capacity list of 32-bit integers, one command per input beat and one result beat
// per command. Entries live in a ring of CAPACITY cells with cell 0 as the only compare tap.
// Clear, append, shift remove, the unused command codes, and any command that fails its
// position check act on acceptance and go straight to the result state. Find first, find
// last and a successful swap remove each turn the ring once through cell 0, and swap remove
// then writes the captured last entry into the freed slot. A new command is accepted while
// the previous result beat is still waiting at the output.
module integer_list_buffer_core
  import ilb_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [CMD_W-1:0]          command_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic [POS_W-1:0]          position_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      ok_o,
  output logic [FOUND_W-1:0]        found_at_o,
  output logic [FILL_W-1:0]         fill_o
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  cell_ctl_t          ctl;
  logic [CNT_W-1:0]   addr;
  logic [VALUE_W-1:0] cell_data [CAPACITY];

  ilb_ctrl #(
    .CAPACITY(CAPACITY),
    .CNT_W   (CNT_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .value_i    (value_i),
    .position_i (position_i),
    .head_i     (cell_data[0]),
    .ctl_o      (ctl),
    .addr_o     (addr),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .ok_o       (ok_o),
    .found_at_o (found_at_o),
    .fill_o     (fill_o)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int Nxt = (g + 1) % CAPACITY;
    ilb_cell #(
      .IDX   (g),
      .ADDR_W(CNT_W)
    ) u_cell (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .addr_i(addr),
      .next_i(cell_data[Nxt]),
      .data_o(cell_data[g])
    );
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("command accepted without the block going busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat appeared while the block was idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (found_at_o == '0))
    else $error("failed command reports a nonzero position");

endmodule

// ===== bench/testbench.sv =====
module testbench;
  import ilb_pkg::*;

  localparam int CAPACITY     = 256;
  localparam int RANDOM_ITEMS = 1650;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int BLOCK_LEN    = 50;

  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] VAL_NEG = -32'sd1;

  localparam logic signed [VALUE_W-1:0] VALUE_POOL [8] = '{
    VAL_MIN, VAL_MAX, 32'sd0, VAL_NEG, 32'sd1, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sd42
  };

  localparam logic [CMD_W-1:0] MIX_CODES [7] = '{
    CMD_CLEAR, CMD_APPEND, CMD_SWAP_REMOVE, CMD_SHIFT_REMOVE,
    CMD_FIND_FIRST, CMD_FIND_LAST, CMD_SPARE_6
  };

  typedef enum int {
    MIX_GROW,
    MIX_EVEN,
    MIX_DRAIN,
    MIX_FILL
  } mix_e;

  // cumulative percent cut points over MIX_CODES, one row per mix
  localparam int MIX_CUTS [4][6] = '{
    '{1, 61, 67, 73, 86, 99},
    '{3, 38, 52, 66, 82, 97},
    '{3, 13, 40, 67, 82, 97},
    '{0, 85, 88, 91, 95, 99}
  };

  typedef struct packed {
    logic               ok;
    logic [FOUND_W-1:0] found_at;
    logic [FILL_W-1:0]  fill;
  } list_result_t;

  typedef struct {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
    bit                        typed;
    list_result_t              result;
  } stim_row_t;

  localparam list_result_t NO_RESULT = '0;

  stim_row_t directed_rows [25] = '{
    '{CMD_FIND_FIRST,   32'sd0,  8'd0,   1'b1, '{1'b0, 8'd0, 9'd0}},
    '{CMD_SWAP_REMOVE,  32'sd0,  8'd0,   1'b1, '{1'b0, 8'd0, 9'd0}},
    '{CMD_SHIFT_REMOVE, 32'sd0,  8'd255, 1'b1, '{1'b0, 8'd0, 9'd0}},
    '{CMD_APPEND,       VAL_MIN, 8'd0,   1'b1, '{1'b1, 8'd0, 9'd1}},
    '{CMD_APPEND,       VAL_MAX, 8'd0,   1'b1, '{1'b1, 8'd0, 9'd2}},
    '{CMD_APPEND,       VAL_MIN, 8'd0,   1'b1, '{1'b1, 8'd0, 9'd3}},
    '{CMD_APPEND,       32'sd0,  8'd0,   1'b1, '{1'b1, 8'd0, 9'd4}},
    '{CMD_APPEND,       VAL_NEG, 8'd255, 1'b1, '{1'b1, 8'd0, 9'd5}},
    '{CMD_FIND_FIRST,   VAL_MIN, 8'd0,   1'b1, '{1'b1, 8'd0, 9'd5}},
    '{CMD_FIND_LAST,    VAL_MIN, 8'd0,   1'b1, '{1'b1, 8'd2, 9'd5}},
    '{CMD_FIND_FIRST,   VAL_MAX, 8'd0,   1'b0, NO_RESULT},
    '{CMD_FIND_LAST,    32'sd5,  8'd0,   1'b1, '{1'b0, 8'd0, 9'd5}},
    '{CMD_SPARE_6,      32'sd0,  8'd0,   1'b1, '{1'b0, 8'd0, 9'd5}},
    '{CMD_SPARE_7,      VAL_NEG, 8'd255, 1'b1, '{1'b0, 8'd0, 9'd5}},
    '{CMD_SWAP_REMOVE,  32'sd0,  8'd5,   1'b1, '{1'b0, 8'd0, 9'd5}},
    '{CMD_SWAP_REMOVE,  32'sd0,  8'd0,   1'b0, NO_RESULT},
    '{CMD_SHIFT_REMOVE, 32'sd0,  8'd1,   1'b0, NO_RESULT},
    '{CMD_SHIFT_REMOVE, 32'sd0,  8'd255, 1'b1, '{1'b0, 8'd0, 9'd3}},
    '{CMD_FIND_LAST,    VAL_NEG, 8'd0,   1'b0, NO_RESULT},
    '{CMD_SWAP_REMOVE,  32'sd0,  8'd2,   1'b0, NO_RESULT},
    '{CMD_FIND_FIRST,   32'sd0,  8'd0,   1'b0, NO_RESULT},
    '{CMD_CLEAR,        VAL_MAX, 8'd255, 1'b1, '{1'b1, 8'd0, 9'd0}},
    '{CMD_FIND_FIRST,   VAL_NEG, 8'd0,   1'b1, '{1'b0, 8'd0, 9'd0}},
    '{CMD_APPEND,       VAL_MAX, 8'd0,   1'b1, '{1'b1, 8'd0, 9'd1}},
    '{CMD_SHIFT_REMOVE, 32'sd0,  8'd0,   1'b0, NO_RESULT}
  };

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [CMD_W-1:0]          command_i;
  logic signed [VALUE_W-1:0] value_i;
  logic [POS_W-1:0]          position_i;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic                      ok_o;
  logic [FOUND_W-1:0]        found_at_o;
  logic [FILL_W-1:0]         fill_o;

  integer_list_buffer_core #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .value_i    (value_i),
    .position_i (position_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .ok_o       (ok_o),
    .found_at_o (found_at_o),
    .fill_o     (fill_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // list state mirrored by the predictor
  logic signed [VALUE_W-1:0] list_mem [CAPACITY];
  int                        list_len = 0;

  list_result_t pending_results [$];
  int           mismatch_count = 0;
  bit           send_quiet = 1'b0;
  bit           recv_quiet = 1'b0;
  int           results_seen = 0;
  int           hold_left = 0;
  list_result_t want;

  function automatic list_result_t list_apply(input logic [CMD_W-1:0] cmd,
                                              input logic signed [VALUE_W-1:0] val,
                                              input logic [POS_W-1:0] pos);
    list_result_t r;
    int           i;
    r = '0;
    case (cmd)
      CMD_CLEAR: begin
        list_len = 0;
        r.ok = 1'b1;
      end
      CMD_APPEND: begin
        if (list_len < CAPACITY) begin
          list_mem[list_len] = val;
          list_len++;
          r.ok = 1'b1;
        end
      end
      CMD_SWAP_REMOVE: begin
        if (int'(pos) < list_len) begin
          list_mem[pos] = list_mem[list_len-1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      CMD_SHIFT_REMOVE: begin
        if (int'(pos) < list_len) begin
          list_len--;
          for (i = int'(pos); i < list_len; i++) list_mem[i] = list_mem[i+1];
          r.ok = 1'b1;
        end
      end
      CMD_FIND_FIRST: begin
        for (i = 0; i < list_len; i++) begin
          if (!r.ok && list_mem[i] == val) begin
            r.ok = 1'b1;
            r.found_at = i[FOUND_W-1:0];
          end
        end
      end
      CMD_FIND_LAST: begin
        for (i = list_len - 1; i >= 0; i--) begin
          if (!r.ok && list_mem[i] == val) begin
            r.ok = 1'b1;
            r.found_at = i[FOUND_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
    r.fill = list_len[FILL_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned exp_val,
                                 input int unsigned got_val);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at result %0d, %s: expected %0d, got %0d",
               results_seen, what, exp_val, got_val);
  endtask

  task automatic send_command(input logic [CMD_W-1:0] cmd,
                              input logic signed [VALUE_W-1:0] val,
                              input logic [POS_W-1:0] pos,
                              input bit typed, input list_result_t typed_result);
    int           gap;
    list_result_t predicted;
    gap = send_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    value_i    <= val;
    position_i <= pos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = list_apply(cmd, val, pos);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  // result side: check each beat, then stall a random number of valid cycles
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", 0, 1);
      end else begin
        want = pending_results.pop_front();
        if (ok_o !== want.ok) report_mismatch("ok", want.ok, ok_o);
        if (found_at_o !== want.found_at) report_mismatch("found_at", want.found_at, found_at_o);
        if (fill_o !== want.fill) report_mismatch("fill", want.fill, fill_o);
      end
      results_seen++;
      if (results_seen % 64 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
      hold_left = recv_quiet ? 0 : $urandom_range(0, 7);
    end else if (out_valid_o === 1'b1 && hold_left > 0) begin
      hold_left--;
    end
    out_stall_i <= (hold_left != 0);
  end

  initial begin
    int                        n;
    int                        roll;
    int                        pick;
    int                        blk;
    int                        block_left;
    int                        fill_tail;
    bit                        is_find;
    mix_e                      mix;
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] val;
    logic [POS_W-1:0]          pos;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    command_i  = CMD_CLEAR;
    value_i    = '0;
    position_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k])
      send_command(directed_rows[k].cmd, directed_rows[k].value, directed_rows[k].pos,
                   directed_rows[k].typed, directed_rows[k].result);

    n          = 0;
    blk        = 0;
    block_left = BLOCK_LEN;
    fill_tail  = 0;
    mix        = MIX_EVEN;
    while (n < RANDOM_ITEMS) begin
      // fill mode runs until the list is full and then a little past it
      if (mix == MIX_FILL) begin
        if (list_len == CAPACITY) fill_tail++;
        if (fill_tail > 12) begin
          mix        = MIX_DRAIN;
          block_left = BLOCK_LEN;
        end
      end else if (block_left == 0) begin
        blk++;
        roll       = $urandom_range(0, 7);
        mix        = (blk == 3 || roll == 0) ? MIX_FILL : mix_e'(roll % 3);
        fill_tail  = 0;
        block_left = BLOCK_LEN;
        send_quiet = ($urandom_range(0, 3) == 0);
      end
      if (block_left > 0) block_left--;

      roll = $urandom_range(0, 99);
      pick = 0;
      while (pick < 6 && roll >= MIX_CUTS[mix][pick]) pick++;
      cmd = MIX_CODES[pick];
      if (cmd == CMD_SPARE_6 && $urandom_range(0, 1) == 1) cmd = CMD_SPARE_7;
      is_find = (cmd == CMD_FIND_FIRST || cmd == CMD_FIND_LAST);

      roll = $urandom_range(0, 9);
      if (is_find && list_len > 0 && roll < 6) val = list_mem[$urandom_range(0, list_len - 1)];
      else if (roll < 7) val = VALUE_POOL[$urandom_range(0, 7)];
      else val = $urandom;

      roll = $urandom_range(0, 19);
      if (list_len > 0 && roll < 15) begin
        if (roll < 3) pos = '0;
        else if (roll < 6) pos = POS_W'(list_len - 1);
        else pos = POS_W'($urandom_range(0, list_len - 1));
      end else if (roll < 17 && list_len < CAPACITY) begin
        pos = POS_W'(list_len);
      end else begin
        pos = POS_W'($urandom_range(0, 255));
      end

      send_command(cmd, val, pos, 1'b0, NO_RESULT);
      if (cmd != CMD_SPARE_6 && cmd != CMD_SPARE_7) n++;
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (CAPACITY + 16) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
